// ===== sv/tvsg_pkg.sv =====
// types, port codes and tables shared by the three-voice sound generator
package tvsg_pkg;

    // operation codes of the input word
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SELECT = 2'd1,
        OP_WRITE  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam int NUM_VOICES = 3;

    // register port codes, one per voice where the register is per voice
    localparam logic [4:0] PORT_TONE_LO [NUM_VOICES] = '{5'h00, 5'h02, 5'h04};
    localparam logic [4:0] PORT_TONE_HI [NUM_VOICES] = '{5'h01, 5'h03, 5'h05};
    localparam logic [4:0] PORT_VOLUME  [NUM_VOICES] = '{5'h08, 5'h09, 5'h0A};
    localparam logic [4:0] PORT_ENV_LO  [NUM_VOICES] = '{5'h0B, 5'h10, 5'h12};
    localparam logic [4:0] PORT_ENV_HI  [NUM_VOICES] = '{5'h0C, 5'h11, 5'h13};
    localparam logic [4:0] PORT_SHAPE   [NUM_VOICES] = '{5'h0D, 5'h14, 5'h15};
    localparam logic [4:0] PORT_DUTY    [NUM_VOICES] = '{5'h16, 5'h17, 5'h18};
    localparam logic [4:0] PORT_NOISE_PERIOD = 5'h06;
    localparam logic [4:0] PORT_MIXER        = 5'h07;
    localparam logic [4:0] PORT_NOISE_AND    = 5'h19;
    localparam logic [4:0] PORT_NOISE_OR     = 5'h1A;

    // reset values and limits
    localparam logic [16:0] LFSR_RESET         = 17'h1FFFF;
    localparam logic [12:0] NOISE_PERIOD_RESET = 13'h1FE0;
    localparam logic [12:0] NOISE_PERIOD_MIN   = 13'h0010;
    localparam logic [7:0]  NOISE_AND_RESET    = 8'hFF;
    localparam logic [18:0] ENV_COUNT_MAX      = 19'h7FFFF;
    localparam logic [5:0]  ENV_LEVEL_TOP      = 6'h1F;

    // register writes decoded for one voice
    typedef struct packed {
        logic tone_lo;
        logic tone_hi;
        logic volume;
        logic env_lo;
        logic env_hi;
        logic shape;
        logic duty;
        logic mixer;
        logic tone_off;
        logic noise_off;
    } t_voice_wr;

    // exponential volume curve
    function automatic logic [7:0] vol_curve(input logic [4:0] lvl);
        logic [7:0] v;
        case (lvl)
            5'd0:  v = 8'd1;   5'd1:  v = 8'd1;   5'd2:  v = 8'd1;   5'd3:  v = 8'd2;
            5'd4:  v = 8'd2;   5'd5:  v = 8'd2;   5'd6:  v = 8'd3;   5'd7:  v = 8'd4;
            5'd8:  v = 8'd4;   5'd9:  v = 8'd5;   5'd10: v = 8'd6;   5'd11: v = 8'd7;
            5'd12: v = 8'd9;   5'd13: v = 8'd11;  5'd14: v = 8'd13;  5'd15: v = 8'd15;
            5'd16: v = 8'd18;  5'd17: v = 8'd22;  5'd18: v = 8'd26;  5'd19: v = 8'd31;
            5'd20: v = 8'd37;  5'd21: v = 8'd45;  5'd22: v = 8'd53;  5'd23: v = 8'd63;
            5'd24: v = 8'd75;  5'd25: v = 8'd90;  5'd26: v = 8'd107; 5'd27: v = 8'd127;
            5'd28: v = 8'd151; 5'd29: v = 8'd180; 5'd30: v = 8'd214;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // number of leading high steps in each 32-step duty pattern
    function automatic logic [4:0] duty_high(input logic [3:0] sel);
        logic [4:0] h;
        case (sel)
            4'd0: h = 5'd1;
            4'd1: h = 5'd2;
            4'd2: h = 5'd4;
            4'd3: h = 5'd8;
            4'd4: h = 5'd16;
            4'd5: h = 5'd24;
            4'd6: h = 5'd28;
            4'd7: h = 5'd30;
            default: h = 5'd31;
        endcase
        return h;
    endfunction

endpackage

// ===== sv/tvsg_if.sv =====
// valid/ready channel interfaces for command words and level words
interface tvsg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface tvsg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] voice_a_level;
    logic [7:0] voice_b_level;
    logic [7:0] voice_c_level;

    modport source (output valid, output voice_a_level, output voice_b_level,
                    output voice_c_level, input ready);
    modport sink (input valid, input voice_a_level, input voice_b_level,
                  input voice_c_level, output ready);
endinterface

// ===== sv/tvsg_voice.sv =====
// one voice: tone counter, duty pattern, envelope and gated volume
module tvsg_voice (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  tvsg_pkg::t_voice_wr  i_wr,
    input  logic [7:0]           i_value,
    input  logic                 i_noise_bit,
    output logic [7:0]           o_level
);

    logic [15:0] r_tone_period, n_tone_period;
    logic [15:0] r_tone_count,  n_tone_count;
    logic [7:0]  r_duty_select, n_duty_select;
    logic [4:0]  r_duty_step,   n_duty_step;
    logic [7:0]  r_volume,      n_volume;
    logic [18:0] r_env_period,  n_env_period;
    logic [18:0] r_env_count,   n_env_count;
    logic [5:0]  r_env_level,   n_env_level;
    logic [7:0]  r_env_shape,   n_env_shape;
    logic        r_env_hold,    n_env_hold;
    logic        r_tone_off,    n_tone_off;
    logic        r_noise_off,   n_noise_off;

    logic [18:0] env_inc;
    logic [15:0] tone_inc;
    logic [5:0]  lvl_step;
    logic [7:0]  shape_step;
    logic        hold_step;

    // register writes and one tick of envelope then tone
    always_comb begin
        n_tone_period = r_tone_period;
        n_tone_count  = r_tone_count;
        n_duty_select = r_duty_select;
        n_duty_step   = r_duty_step;
        n_volume      = r_volume;
        n_env_period  = r_env_period;
        n_env_count   = r_env_count;
        n_env_level   = r_env_level;
        n_env_shape   = r_env_shape;
        n_env_hold    = r_env_hold;
        n_tone_off    = r_tone_off;
        n_noise_off   = r_noise_off;
        env_inc    = (r_env_count != tvsg_pkg::ENV_COUNT_MAX) ? r_env_count + 19'd1
                                                              : r_env_count;
        tone_inc   = r_tone_count + 16'd1;
        lvl_step   = r_env_level;
        shape_step = r_env_shape;
        hold_step  = r_env_hold;

        if (i_wr.tone_lo) n_tone_period = {r_tone_period[15:8], i_value};
        if (i_wr.tone_hi) n_tone_period = {i_value, r_tone_period[7:0]};
        if (i_wr.volume)  n_volume = i_value;
        if (i_wr.duty)    n_duty_select = i_value;
        if (i_wr.env_lo)  n_env_period = {r_env_period[18:11], i_value, 3'b000};
        if (i_wr.env_hi)  n_env_period = {i_value, r_env_period[10:3], 3'b000};
        if (i_wr.mixer) begin
            n_tone_off  = i_wr.tone_off;
            n_noise_off = i_wr.noise_off;
        end
        if (i_wr.shape) begin
            n_env_count = '0;
            n_env_shape = i_value;
            n_env_hold  = 1'b0;
            n_env_level = i_value[2] ? 6'd0 : tvsg_pkg::ENV_LEVEL_TOP;
        end

        if (i_tick) begin
            // envelope period counter, saturating when idle
            n_env_count = env_inc;
            if (r_env_period != '0 && env_inc >= r_env_period) begin
                n_env_count = '0;
                if (!r_env_hold) begin
                    lvl_step = r_env_level + (r_env_shape[2] ? 6'd1 : 6'h3F);
                end
                if (lvl_step[5]) begin
                    if (r_env_shape[3]) begin
                        if (r_env_shape[1:0] == 2'd1 || r_env_shape[1:0] == 2'd2) begin
                            shape_step[2] = ~r_env_shape[2];
                        end
                        if (shape_step[0]) hold_step = 1'b1;
                        lvl_step = shape_step[2] ? 6'd0 : tvsg_pkg::ENV_LEVEL_TOP;
                    end else begin
                        hold_step = 1'b1;
                        lvl_step  = 6'd0;
                    end
                end
                n_env_level = lvl_step;
                n_env_shape = shape_step;
                n_env_hold  = hold_step;
            end
            // tone counter and duty step
            n_tone_count = tone_inc;
            if (tone_inc >= r_tone_period) begin
                n_tone_count = '0;
                n_duty_step  = r_duty_step + 5'd1;
            end
        end
    end

    // gated level from the state after this tick
    logic [4:0] vol_idx;
    logic       duty_hi;
    always_comb begin
        vol_idx = n_volume[5] ? n_env_level[4:0] : n_volume[4:0];
        duty_hi = n_duty_step < tvsg_pkg::duty_high(n_duty_select[3:0]);
        o_level = tvsg_pkg::vol_curve(vol_idx);
        if (!n_tone_off && !duty_hi && n_tone_period >= 16'd2) o_level = 8'd0;
        if (!n_noise_off && !i_noise_bit) o_level = 8'd0;
    end

    // voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_period <= '0;
            r_tone_count  <= '0;
            r_duty_select <= '0;
            r_duty_step   <= '0;
            r_volume      <= '0;
            r_env_period  <= '0;
            r_env_count   <= '0;
            r_env_level   <= '0;
            r_env_shape   <= '0;
            r_env_hold    <= 1'b1;
            r_tone_off    <= 1'b1;
            r_noise_off   <= 1'b1;
        end else begin
            r_tone_period <= n_tone_period;
            r_tone_count  <= n_tone_count;
            r_duty_select <= n_duty_select;
            r_duty_step   <= n_duty_step;
            r_volume      <= n_volume;
            r_env_period  <= n_env_period;
            r_env_count   <= n_env_count;
            r_env_level   <= n_env_level;
            r_env_shape   <= n_env_shape;
            r_env_hold    <= n_env_hold;
            r_tone_off    <= n_tone_off;
            r_noise_off   <= n_noise_off;
        end
    end

endmodule

// ===== sv/three_voice_sound_generator_top.sv =====
// three-voice sound generator top level: command decode, noise source, output buffer
//
// Each accepted command word is one of: a tick, a port select or a data write to the
// selected port. All state updates in the cycle the word is accepted, so a new word
// is taken every clock unless the input stalls; each tick yields one level word (three
// 8-bit voice levels), registered in the output register, or in the skid register if
// the sink stalls. A two-deep output buffer (output register plus skid register) lets
// one more tick in while the sink stalls, and select and write words keep flowing;
// the input stalls only when both entries hold undelivered level words.
module three_voice_sound_generator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tvsg_in_if.sink           i_in,
    tvsg_out_if.source        o_out
);

    localparam int NV = tvsg_pkg::NUM_VOICES;

    logic accept, tick, wr;
    logic [7:0] value;

    // output buffer state
    logic       r_out_valid, r_skid_valid;
    logic [7:0] r_out_level  [NV];
    logic [7:0] r_skid_level [NV];
    logic [7:0] new_level    [NV];

    assign i_in.ready = !r_skid_valid;
    assign accept = i_in.valid && i_in.ready;
    assign tick   = accept && (i_in.op == tvsg_pkg::OP_TICK);
    assign wr     = accept && (i_in.op == tvsg_pkg::OP_WRITE);
    assign value  = i_in.value;

    // port select
    logic [4:0] r_port_select;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_select <= '0;
        end else if (accept && i_in.op == tvsg_pkg::OP_SELECT) begin
            r_port_select <= value[4:0];
        end
    end

    // noise source state
    logic [16:0] r_lfsr, n_lfsr;
    logic [12:0] r_noise_period, n_noise_period;
    logic [12:0] r_noise_count, n_noise_count;
    logic [7:0]  r_noise_step, n_noise_step;
    logic        r_noise_bit, n_noise_bit;
    logic [7:0]  r_noise_and, n_noise_and;
    logic [7:0]  r_noise_or, n_noise_or;
    logic [12:0] noise_inc;
    logic [7:0]  noise_thr;

    // noise writes and one tick at twice the tick rate
    always_comb begin
        n_lfsr         = r_lfsr;
        n_noise_period = r_noise_period;
        n_noise_count  = r_noise_count;
        n_noise_step   = r_noise_step;
        n_noise_bit    = r_noise_bit;
        n_noise_and    = r_noise_and;
        n_noise_or     = r_noise_or;
        noise_inc = r_noise_count + 13'd2;
        noise_thr = (r_lfsr[7:0] & r_noise_and) | r_noise_or;

        if (wr && r_port_select == tvsg_pkg::PORT_NOISE_PERIOD) begin
            n_noise_period = (value != 8'd0) ? {value, 5'b00000}
                                             : tvsg_pkg::NOISE_PERIOD_MIN;
        end
        if (wr && r_port_select == tvsg_pkg::PORT_NOISE_AND) n_noise_and = value;
        if (wr && r_port_select == tvsg_pkg::PORT_NOISE_OR)  n_noise_or  = value;

        if (tick) begin
            n_noise_count = noise_inc;
            if (noise_inc >= r_noise_period) begin
                n_noise_count = noise_inc - r_noise_period;
                n_noise_step  = r_noise_step + 8'd1;
                if (r_noise_step >= noise_thr) begin
                    n_noise_step = 8'd1;
                    n_noise_bit  = ~r_noise_bit;
                    n_lfsr       = {r_lfsr[0] ^ r_lfsr[2], r_lfsr[16:1]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr         <= tvsg_pkg::LFSR_RESET;
            r_noise_period <= tvsg_pkg::NOISE_PERIOD_RESET;
            r_noise_count  <= '0;
            r_noise_step   <= '0;
            r_noise_bit    <= 1'b0;
            r_noise_and    <= tvsg_pkg::NOISE_AND_RESET;
            r_noise_or     <= '0;
        end else begin
            r_lfsr         <= n_lfsr;
            r_noise_period <= n_noise_period;
            r_noise_count  <= n_noise_count;
            r_noise_step   <= n_noise_step;
            r_noise_bit    <= n_noise_bit;
            r_noise_and    <= n_noise_and;
            r_noise_or     <= n_noise_or;
        end
    end

    // per-voice write decode and voices
    for (genvar v = 0; v < NV; v++) begin : g_voice
        tvsg_pkg::t_voice_wr voice_wr;

        always_comb begin
            voice_wr.tone_lo   = wr && r_port_select == tvsg_pkg::PORT_TONE_LO[v];
            voice_wr.tone_hi   = wr && r_port_select == tvsg_pkg::PORT_TONE_HI[v];
            voice_wr.volume    = wr && r_port_select == tvsg_pkg::PORT_VOLUME[v];
            voice_wr.env_lo    = wr && r_port_select == tvsg_pkg::PORT_ENV_LO[v];
            voice_wr.env_hi    = wr && r_port_select == tvsg_pkg::PORT_ENV_HI[v];
            voice_wr.shape     = wr && r_port_select == tvsg_pkg::PORT_SHAPE[v];
            voice_wr.duty      = wr && r_port_select == tvsg_pkg::PORT_DUTY[v];
            voice_wr.mixer     = wr && r_port_select == tvsg_pkg::PORT_MIXER;
            voice_wr.tone_off  = value[v];
            voice_wr.noise_off = value[v + 3];
        end

        tvsg_voice u_voice (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tick      (tick),
            .i_wr        (voice_wr),
            .i_value     (value),
            .i_noise_bit (n_noise_bit),
            .o_level     (new_level[v])
        );
    end

    // output register with skid register behind it
    logic out_free;
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || tick;
            r_skid_valid <= 1'b0;
        end else if (tick) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_level <= r_skid_valid ? r_skid_level : new_level;
        end
        if (!r_skid_valid) begin
            r_skid_level <= new_level;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.voice_a_level = r_out_level[0];
    assign o_out.voice_b_level = r_out_level[1];
    assign o_out.voice_c_level = r_out_level[2];

endmodule

// ===== sv/tvsg_checker.sv =====
// port-level checks for the three-voice sound generator, bound to the top level
module tvsg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_op,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_a,
    input logic [7:0] out_b,
    input logic [7:0] out_c
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // a stalled level word stays and holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_b)
                                    && $stable(out_c))
        else $error("level word dropped or changed while stalled");

    // a tick into an empty output shows a word on the next clock
    a_tick_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid && in_acc && in_op == tvsg_pkg::OP_TICK |=> out_valid)
        else $error("tick produced no level word");

    // select and write words produce no level word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid && in_acc && in_op != tvsg_pkg::OP_TICK |=> !out_valid)
        else $error("level word without a tick");

    // input stalls only behind a pending level word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

endmodule

bind three_voice_sound_generator_top tvsg_checker u_tvsg_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_op     (i_in.op),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_a     (o_out.voice_a_level),
    .out_b     (o_out.voice_b_level),
    .out_c     (o_out.voice_c_level)
);
